// ----- rtl/swr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package swr_pkg;

    localparam int unsigned BINS_DEF          = 512;
    localparam int unsigned FRAMES_DEF        = 40;
    localparam int unsigned PLOT_WIDTH_DEF    = 600;
    localparam int unsigned PLOT_HEIGHT_DEF   = 360;
    localparam int unsigned FRAME_SPACING_DEF = 10;
    localparam int unsigned BIN_STEP_DEF      = 3;

    localparam logic [7:0] PIXEL_TOP = 8'd255;

    // configuration register indexes
    localparam logic [7:0] REG_DIVISOR = 8'd0;
    localparam logic [7:0] REG_HEIGHT  = 8'd1;

    typedef enum logic {
        KIND_PUSH = 1'b0,
        KIND_READ = 1'b1
    } kind_t;

    // one classified item between front and back
    typedef struct packed {
        kind_t      kind;
        logic [7:0] level;
        logic [7:0] column_group;
        logic [8:0] row;
    } work_t;

    // largest o with 2*o*o <= q*q; elaboration only
    function automatic int unsigned half_sqrt(input int unsigned q);
        int unsigned o;
        begin
            o = 0;
            while (2 * (o + 1) * (o + 1) <= q * q)
            begin
                o = o + 1;
            end
            return o;
        end
    endfunction

endpackage
`default_nettype wire

// ----- rtl/swr_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
module swr_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// ----- rtl/swr_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
module swr_queue import swr_pkg::*; (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  wire work_t push_data,
    output logic       full,
    input  wire logic  pop,
    output logic       empty,
    output work_t      pop_data
);

    localparam int unsigned DEPTH = 4;

    work_t      entry_reg [DEPTH];
    logic [1:0] wr_ptr_reg;
    logic [1:0] rd_ptr_reg;
    logic [2:0] count_reg;

    assign full     = (count_reg == 3'(DEPTH));
    assign empty    = (count_reg == 3'd0);
    assign pop_data = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push && !full)
            begin
                wr_ptr_reg <= wr_ptr_reg + 2'd1;
            end
            if (pop && !empty)
            begin
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            end
            if ((push && !full) && !(pop && !empty))
            begin
                count_reg <= count_reg + 3'd1;
            end
            else if (!(push && !full) && (pop && !empty))
            begin
                count_reg <= count_reg - 3'd1;
            end
        end
    end

endmodule
`default_nettype wire

// ----- rtl/swr_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
module swr_front import swr_pkg::*; (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire kind_t       in_kind,
    input  wire logic [31:0] in_sample,
    input  wire logic [7:0]  in_group,
    input  wire logic [8:0]  in_row,
    input  wire logic [15:0] divisor,
    input  wire logic [7:0]  height_max,
    output logic             q_push,
    output work_t            q_data,
    input  wire logic        q_full
);

    typedef enum logic [1:0] {
        F_IDLE,
        F_DIV,
        F_PUSH
    } state_t;

    state_t      state_reg;
    logic [30:0] dvd_reg;
    logic [15:0] rem_reg;
    logic [15:0] dsr_reg;
    logic [4:0]  cnt_reg;

    logic        accept;
    logic        direct;
    logic [16:0] rem_sh;
    logic        ge;
    logic [16:0] rem_sub;
    logic [7:0]  level_clamped;

    assign in_ready = (state_reg == F_IDLE) && !q_full;
    assign accept   = in_valid && in_ready;
    assign direct   = (in_kind == KIND_READ) || in_sample[31];

    // restoring divide, one quotient bit per cycle
    assign rem_sh  = {rem_reg, dvd_reg[30]};
    assign ge      = rem_sh >= {1'b0, dsr_reg};
    assign rem_sub = rem_sh - {1'b0, dsr_reg};

    assign level_clamped = (dvd_reg > 31'(height_max)) ? height_max : dvd_reg[7:0];

    always_comb
    begin
        q_push = 1'b0;
        q_data = '0;
        if (state_reg == F_PUSH)
        begin
            q_push       = !q_full;
            q_data.kind  = KIND_PUSH;
            q_data.level = level_clamped;
        end
        else if (accept && direct)
        begin
            q_push              = 1'b1;
            q_data.kind         = in_kind;
            q_data.column_group = in_group;
            q_data.row          = in_row;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            dvd_reg   <= '0;
            rem_reg   <= '0;
            dsr_reg   <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                F_IDLE:
                begin
                    if (accept && !direct)
                    begin
                        dvd_reg   <= in_sample[30:0];
                        rem_reg   <= '0;
                        dsr_reg   <= (divisor == 16'd0) ? 16'd1 : divisor;
                        cnt_reg   <= 5'd30;
                        state_reg <= F_DIV;
                    end
                end
                F_DIV:
                begin
                    rem_reg <= ge ? rem_sub[15:0] : rem_sh[15:0];
                    dvd_reg <= {dvd_reg[29:0], ge};
                    cnt_reg <= cnt_reg - 5'd1;
                    if (cnt_reg == 5'd0)
                    begin
                        state_reg <= F_PUSH;
                    end
                end
                F_PUSH:
                begin
                    if (!q_full)
                    begin
                        state_reg <= F_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

// ----- rtl/swr_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
module swr_back import swr_pkg::*; #(
    parameter int unsigned BINS          = BINS_DEF,
    parameter int unsigned FRAMES        = FRAMES_DEF,
    parameter int unsigned PLOT_WIDTH    = PLOT_WIDTH_DEF,
    parameter int unsigned PLOT_HEIGHT   = PLOT_HEIGHT_DEF,
    parameter int unsigned FRAME_SPACING = FRAME_SPACING_DEF,
    parameter int unsigned BIN_STEP      = BIN_STEP_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        q_empty,
    output logic             q_pop,
    input  wire work_t       q_data,
    input  wire logic [7:0]  height_max,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      out_pixel_word,
    output logic [7:0]       out_level,
    output logic             out_frame_rendered
);

    localparam int unsigned HDEPTH = FRAMES * BINS;
    localparam int unsigned HAW    = $clog2(HDEPTH);
    localparam int unsigned GROUPS = (PLOT_WIDTH + 3) / 4;
    localparam int unsigned PDEPTH = GROUPS * PLOT_HEIGHT;
    localparam int unsigned PAW    = $clog2(PDEPTH);
    localparam int unsigned SW     = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int unsigned VW     = $clog2(FRAMES + 1);
    localparam int unsigned BW     = $clog2(BINS);
    localparam int unsigned RW     = (BIN_STEP > 1) ? $clog2(BIN_STEP) : 1;
    localparam int unsigned CW     = $clog2(FRAME_SPACING * FRAMES + BINS + 1);
    localparam int unsigned PRW    = $clog2(BINS + PLOT_HEIGHT + 257);
    localparam int unsigned SQW    = 2 * BW + 1;
    localparam int unsigned Q0     = (BINS - 1) / BIN_STEP;
    localparam int unsigned R0     = (BINS - 1) % BIN_STEP;
    localparam int unsigned O0     = half_sqrt(Q0);

    typedef enum logic [2:0] {
        B_IDLE,
        B_READ,
        B_READ_DATA,
        B_CLEAR,
        B_HREAD,
        B_LEVEL,
        B_PAINT
    } state_t;

    state_t          state_reg;
    logic [BW-1:0]   fill_reg;
    logic [SW-1:0]   oldest_reg;
    logic [VW-1:0]   valid_reg;
    logic            drawn_reg;
    logic [7:0]      group_reg;
    logic [8:0]      row_reg;
    logic [PAW-1:0]  clr_reg;
    logic [SW-1:0]   frame_reg;
    logic [SW-1:0]   slot_reg;
    logic [CW-1:0]   col_base_reg;
    logic [BW-1:0]   bin_reg;
    logic [BW-1:0]   q_reg;
    logic [RW-1:0]   rem_reg;
    logic [BW-1:0]   o_reg;
    logic [7:0]      r_reg;
    logic            out_valid_reg;
    logic [31:0]     out_pixel_reg;
    logic [7:0]      out_level_reg;
    logic            out_done_reg;

    logic            pop_ok;
    logic            frame_full;
    logic            hist_we;
    logic [HAW-1:0]  hist_waddr;
    logic [HAW-1:0]  hist_raddr;
    logic [7:0]      hist_rdata;
    logic [3:0]      plot_we;
    logic [PAW-1:0]  plot_waddr;
    logic [7:0]      plot_wdata;
    logic [PAW-1:0]  plot_raddr;
    logic [7:0]      plot_rdata [4];
    logic [31:0]     read_word;
    logic            read_in;
    logic [CW-1:0]   col;
    logic [PRW-1:0]  prow;
    logic [BW-1:0]   q_dec;
    logic [SQW-1:0]  o_sq2;
    logic [SQW-1:0]  q_sq;
    logic            o_drop;
    logic            slot_valid;
    logic            paint_ok;
    logic            paint_last;
    logic            advance;

    assign pop_ok     = (state_reg == B_IDLE) && !q_empty && (!out_valid_reg || out_ready);
    assign q_pop      = pop_ok;
    assign frame_full = (fill_reg == BW'(BINS - 1));

    assign hist_we    = pop_ok && (q_data.kind == KIND_PUSH);
    assign hist_waddr = HAW'(oldest_reg) * HAW'(BINS) + HAW'(fill_reg);
    assign hist_raddr = HAW'(slot_reg) * HAW'(BINS) + HAW'(bin_reg);

    swr_ram #(
        .WIDTH(8),
        .DEPTH(HDEPTH)
    ) u_history (
        .clk  (clk),
        .we   (hist_we),
        .waddr(hist_waddr),
        .wdata(q_data.level),
        .raddr(hist_raddr),
        .rdata(hist_rdata)
    );

    assign col        = col_base_reg + CW'(o_reg);
    assign prow       = PRW'(o_reg) + PRW'(r_reg);
    assign q_dec      = q_reg - BW'(1);
    assign o_sq2      = (SQW'(o_reg) * SQW'(o_reg)) << 1;
    assign q_sq       = SQW'(q_dec) * SQW'(q_dec);
    assign o_drop     = o_sq2 > q_sq;
    assign slot_valid = VW'(slot_reg) < valid_reg;
    assign paint_ok   = (hist_rdata != 8'd0) && slot_valid && (col < PLOT_WIDTH)
                        && (o_reg < PLOT_HEIGHT);
    assign paint_last = (r_reg == hist_rdata) || (prow >= PRW'(PLOT_HEIGHT - 1));
    assign advance    = ((state_reg == B_LEVEL) && !paint_ok)
                        || ((state_reg == B_PAINT) && paint_last);

    always_comb
    begin
        plot_we    = 4'b0000;
        plot_waddr = clr_reg;
        plot_wdata = 8'd0;
        if (state_reg == B_CLEAR)
        begin
            plot_we = 4'b1111;
        end
        else if (state_reg == B_PAINT)
        begin
            plot_we[col[1:0]] = 1'b1;
            plot_waddr = PAW'(col[CW-1:2]) * PAW'(PLOT_HEIGHT) + PAW'(prow);
            plot_wdata = PIXEL_TOP - height_max + r_reg;
        end
    end

    assign read_in    = (group_reg < GROUPS) && (row_reg < PLOT_HEIGHT);
    assign plot_raddr = read_in ? (PAW'(group_reg) * PAW'(PLOT_HEIGHT) + PAW'(row_reg))
                                : '0;

    for (genvar k = 0; k < 4; k++)
    begin : g_lane
        swr_ram #(
            .WIDTH(8),
            .DEPTH(PDEPTH)
        ) u_plot (
            .clk  (clk),
            .we   (plot_we[k]),
            .waddr(plot_waddr),
            .wdata(plot_wdata),
            .raddr(plot_raddr),
            .rdata(plot_rdata[k])
        );

        assign read_word[8*k +: 8] =
            (drawn_reg && (row_reg < PLOT_HEIGHT) && ({group_reg, 2'(k)} < PLOT_WIDTH))
            ? plot_rdata[k] : 8'd0;
    end

    assign out_valid          = out_valid_reg;
    assign out_pixel_word     = out_pixel_reg;
    assign out_level          = out_level_reg;
    assign out_frame_rendered = out_done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            fill_reg      <= '0;
            oldest_reg    <= '0;
            valid_reg     <= '0;
            drawn_reg     <= 1'b0;
            group_reg     <= '0;
            row_reg       <= '0;
            clr_reg       <= '0;
            frame_reg     <= '0;
            slot_reg      <= '0;
            col_base_reg  <= '0;
            bin_reg       <= '0;
            q_reg         <= '0;
            rem_reg       <= '0;
            o_reg         <= '0;
            r_reg         <= '0;
            out_valid_reg <= 1'b0;
            out_pixel_reg <= '0;
            out_level_reg <= '0;
            out_done_reg  <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                B_IDLE:
                begin
                    if (pop_ok)
                    begin
                        if (q_data.kind == KIND_READ)
                        begin
                            group_reg <= q_data.column_group;
                            row_reg   <= q_data.row;
                            state_reg <= B_READ;
                        end
                        else
                        begin
                            out_pixel_reg <= '0;
                            out_level_reg <= q_data.level;
                            if (frame_full)
                            begin
                                fill_reg   <= '0;
                                oldest_reg <= (oldest_reg == SW'(FRAMES - 1))
                                              ? '0 : oldest_reg + SW'(1);
                                if (valid_reg != VW'(FRAMES))
                                begin
                                    valid_reg <= valid_reg + VW'(1);
                                end
                                clr_reg   <= '0;
                                state_reg <= B_CLEAR;
                            end
                            else
                            begin
                                fill_reg      <= fill_reg + BW'(1);
                                out_done_reg  <= 1'b0;
                                out_valid_reg <= 1'b1;
                            end
                        end
                    end
                end
                B_READ:
                begin
                    state_reg <= B_READ_DATA;
                end
                B_READ_DATA:
                begin
                    out_pixel_reg <= read_word;
                    out_level_reg <= '0;
                    out_done_reg  <= 1'b0;
                    out_valid_reg <= 1'b1;
                    state_reg     <= B_IDLE;
                end
                B_CLEAR:
                begin
                    clr_reg <= clr_reg + PAW'(1);
                    if (clr_reg == PAW'(PDEPTH - 1))
                    begin
                        drawn_reg    <= 1'b1;
                        frame_reg    <= '0;
                        slot_reg     <= oldest_reg;
                        col_base_reg <= '0;
                        bin_reg      <= BW'(BINS - 1);
                        q_reg        <= BW'(Q0);
                        rem_reg      <= RW'(R0);
                        o_reg        <= BW'(O0);
                        state_reg    <= B_HREAD;
                    end
                end
                B_HREAD:
                begin
                    state_reg <= B_LEVEL;
                end
                B_LEVEL:
                begin
                    r_reg     <= '0;
                    state_reg <= B_PAINT;
                end
                B_PAINT:
                begin
                    r_reg <= r_reg + 8'd1;
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase

            // next bin, next frame, or end of redraw
            if (advance)
            begin
                state_reg <= B_HREAD;
                if (bin_reg == '0)
                begin
                    if (frame_reg == SW'(FRAMES - 1))
                    begin
                        out_done_reg  <= 1'b1;
                        out_valid_reg <= 1'b1;
                        state_reg     <= B_IDLE;
                    end
                    else
                    begin
                        frame_reg    <= frame_reg + SW'(1);
                        slot_reg     <= (slot_reg == SW'(FRAMES - 1)) ? '0 : slot_reg + SW'(1);
                        col_base_reg <= col_base_reg + CW'(FRAME_SPACING);
                        bin_reg      <= BW'(BINS - 1);
                        q_reg        <= BW'(Q0);
                        rem_reg      <= RW'(R0);
                        o_reg        <= BW'(O0);
                    end
                end
                else
                begin
                    bin_reg <= bin_reg - BW'(1);
                    if (rem_reg == '0)
                    begin
                        rem_reg <= RW'(BIN_STEP - 1);
                        q_reg   <= q_dec;
                        if (o_drop)
                        begin
                            o_reg <= o_reg - BW'(1);
                        end
                    end
                    else
                    begin
                        rem_reg <= rem_reg - RW'(1);
                    end
                end
            end
        end
    end

endmodule
`default_nettype wire

// ----- rtl/spectrum_waterfall_renderer_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Channel  | Handshake            | Payload
// s        | s_tvalid / s_tready  | tdata: sample, column_group, row; tuser: kind
// m        | m_tvalid / m_tready  | tdata: pixel_word, level; tuser: frame_rendered
// cfg      | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// Sample push: the serial divider forms 31 quotient bits and F_PUSH writes the queue;
// the back end then pops the item and registers the result.
// Pixel read: the plot memory is read through B_READ and B_READ_DATA, then registered.
// Frame completion: a plot clear of GROUPS*PLOT_HEIGHT words (54000 by default), then
// B_HREAD and B_LEVEL per bin per frame and B_PAINT per pixel; the walk sets the rate.
// Reset needs no clearing pass; history slots count as zero until first filled.
// A 4-entry queue lets the input side keep taking beats while the back end works.
module spectrum_waterfall_renderer_unit import swr_pkg::*; #(
    parameter int unsigned BINS          = BINS_DEF,
    parameter int unsigned FRAMES        = FRAMES_DEF,
    parameter int unsigned PLOT_WIDTH    = PLOT_WIDTH_DEF,
    parameter int unsigned PLOT_HEIGHT   = PLOT_HEIGHT_DEF,
    parameter int unsigned FRAME_SPACING = FRAME_SPACING_DEF,
    parameter int unsigned BIN_STEP      = BIN_STEP_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [55:0] s_tdata,   // sample[31:0], column_group[39:32], row[48:40]
    input  wire logic [0:0]  s_tuser,   // kind[0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // pixel_word[31:0], level[39:32]
    output logic [0:0]       m_tuser,   // frame_rendered[0]
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    logic [15:0] divisor_reg;
    logic [7:0]  height_reg;

    logic        q_push;
    work_t       q_in;
    logic        q_full;
    logic        q_pop;
    logic        q_empty;
    work_t       q_out;
    logic [31:0] pixel_word;
    logic [7:0]  level;
    logic        frame_rendered;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            divisor_reg <= 16'd130;
            height_reg  <= 8'd150;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == REG_DIVISOR)
            begin
                divisor_reg <= cfg_data;
            end
            else if (cfg_index == REG_HEIGHT)
            begin
                height_reg <= cfg_data[7:0];
            end
        end
    end

    swr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_kind   (kind_t'(s_tuser[0])),
        .in_sample (s_tdata[31:0]),
        .in_group  (s_tdata[39:32]),
        .in_row    (s_tdata[48:40]),
        .divisor   (divisor_reg),
        .height_max(height_reg),
        .q_push    (q_push),
        .q_data    (q_in),
        .q_full    (q_full)
    );

    swr_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_data(q_in),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .pop_data (q_out)
    );

    swr_back #(
        .BINS         (BINS),
        .FRAMES       (FRAMES),
        .PLOT_WIDTH   (PLOT_WIDTH),
        .PLOT_HEIGHT  (PLOT_HEIGHT),
        .FRAME_SPACING(FRAME_SPACING),
        .BIN_STEP     (BIN_STEP)
    ) u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .q_empty           (q_empty),
        .q_pop             (q_pop),
        .q_data            (q_out),
        .height_max        (height_reg),
        .out_valid         (m_tvalid),
        .out_ready         (m_tready),
        .out_pixel_word    (pixel_word),
        .out_level         (level),
        .out_frame_rendered(frame_rendered)
    );

    assign m_tdata = {level, pixel_word};
    assign m_tuser = frame_rendered;

endmodule
`default_nettype wire
